>>> sv/sbd_pkg.sv
// Shared types and constants for the stripe breach detector.
package sbd_pkg;

    localparam int NUM_FACES   = 2;
    localparam int NUM_STRIPES = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int FACE_BITS   = 1;
    localparam int STRIPE_BITS = 4;
    localparam int INDEX_BITS  = FACE_BITS + STRIPE_BITS;
    localparam int STORE_DEPTH = NUM_FACES * NUM_STRIPES;
    localparam int TIME_BITS   = 32;
    localparam int COUNT_BITS  = 6;
    localparam int THRESH_BITS = 12;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(500);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

    // Item kinds carried on the input tuser.
    localparam logic OP_BASELINE = 1'b0;
    localparam logic OP_MEASURE  = 1'b1;

    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 48;

    typedef struct packed {
        logic                   op;
        logic [FACE_BITS-1:0]   face_index;
        logic [STRIPE_BITS-1:0] stripe_index;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic [TIME_BITS-1:0]   time_ms;
        logic                   scan_last;
    } item_t;

    typedef struct packed {
        logic                   stripe_breached;
        logic                   new_breach;
        logic [TIME_BITS-1:0]   breach_time;
        logic [COUNT_BITS-1:0]  new_breach_count;
        logic                   log_request;
        logic                   scan_done;
    } result_t;

endpackage

>>> sv/stripe_breach_detector.sv
// Top level of the stripe breach detector.
//
// Samples arrive on the s_axis channel, one beat per stripe reading; tuser says
// whether the beat is a baseline or a measurement, tlast marks the end of a scan.
// Each input beat gives exactly one result beat on m_axis, with tlast echoing the
// end of the scan. The breach threshold is written on the cfg channel, which is
// always ready; the user must write it only while no beat is in flight, as the
// block itself does not enforce this. A beat accepted into the input register is
// evaluated from there, loads into the result register and is shown on m_axis
// from then on. One beat per cycle is taken and delivered in steady state while
// the receiver keeps up; the per-stripe stores are flip-flops read and updated
// in the evaluation cycle, so consecutive beats on the same stripe see each
// other. Reset clears all baselines, breach flags, the scan count and the valid
// bits of both pipeline registers, and loads the threshold with 500. When the
// receiver stalls, the result register holds its beat, the input register
// fills, and s_axis_tready falls until the result is taken.
module stripe_breach_detector
    import sbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // face_index[0], stripe_index[4:1], sample_value[16:5], time_ms[48:17], zero pad
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // op
    input  logic                     s_axis_tuser,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // stripe_breached[0], new_breach[1], breach_time[33:2], new_breach_count[39:34],
    // log_request[40], zero pad
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [THRESH_BITS-1:0]   cfg_data
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    commit;
    result_t result_in;
    result_t result;

    // Unpack the input beat.
    always_comb
    begin
        in_item.op           = s_axis_tuser;
        in_item.face_index   = s_axis_tdata[0];
        in_item.stripe_index = s_axis_tdata[4:1];
        in_item.sample_value = s_axis_tdata[16:5];
        in_item.time_ms      = s_axis_tdata[48:17];
        in_item.scan_last    = s_axis_tlast;
    end

    assign cfg_ready = 1'b1;
    assign commit    = item_valid && advance;

    sbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sbd_stripe_eval u_eval (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_value       (cfg_data),
        .commit          (commit),
        .item            (item),
        .stripe_breached (result_in.stripe_breached),
        .new_breach      (result_in.new_breach),
        .breach_time     (result_in.breach_time)
    );

    sbd_scan_count u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .commit           (commit),
        .new_breach       (result_in.new_breach),
        .scan_last        (item.scan_last),
        .new_breach_count (result_in.new_breach_count),
        .log_request      (result_in.log_request)
    );

    assign result_in.scan_done = item.scan_last;

    sbd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (item_valid),
        .result_in (result_in),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // Pack the result beat.
    assign m_axis_tdata = {7'b0, result.log_request, result.new_breach_count,
                           result.breach_time, result.new_breach, result.stripe_breached};
    assign m_axis_tlast = result.scan_done;

endmodule

>>> sv/sbd_in_reg.sv
// Input register: captures one accepted beat and holds it until evaluation takes it.
module sbd_in_reg
    import sbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up whenever its content moves on in the same cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/sbd_stripe_eval.sv
// Per-stripe stores, threshold register and the deviation check for one item.
module sbd_stripe_eval
    import sbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [THRESH_BITS-1:0] cfg_value,
    input  logic                   commit,
    input  item_t                  item,
    output logic                   stripe_breached,
    output logic                   new_breach,
    output logic [TIME_BITS-1:0]   breach_time
);

    logic [THRESH_BITS-1:0] thresh_reg;
    logic [SAMPLE_BITS-1:0] baseline_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] flags_reg;
    logic [TIME_BITS-1:0]   times_reg [STORE_DEPTH];

    logic [INDEX_BITS-1:0]  idx;
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] dev;
    logic                   over;
    logic                   flag_old;
    logic                   is_measure;

    // Threshold register, to be written only while the block is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            thresh_reg <= cfg_value;
        end
    end

    // Absolute deviation from the stripe's baseline and the threshold compare.
    always_comb
    begin
        idx        = {item.face_index, item.stripe_index};
        base       = baseline_reg[idx];
        dev        = (item.sample_value >= base) ? (item.sample_value - base)
                                                 : (base - item.sample_value);
        over       = dev > thresh_reg;
        flag_old   = flags_reg[idx];
        is_measure = item.op == OP_MEASURE;
    end

    assign stripe_breached = is_measure && over;
    assign new_breach      = is_measure && over && !flag_old;
    // A stored time is only meaningful while its flag is set.
    assign breach_time     = !(is_measure && over) ? '0
                             : (flag_old ? times_reg[idx] : item.time_ms);

    // Baselines and breach flags, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                baseline_reg[i] <= '0;
            end
            flags_reg <= '0;
        end
        else if (commit)
        begin
            if (is_measure)
            begin
                flags_reg[idx] <= over;
            end
            else
            begin
                baseline_reg[idx] <= item.sample_value;
            end
        end
    end

    // Breach start times, stamped when a breach begins.
    always_ff @(posedge clk)
    begin
        if (commit && new_breach)
        begin
            times_reg[idx] <= item.time_ms;
        end
    end

endmodule

>>> sv/sbd_scan_count.sv
// Scan-wide count of new breaches and the log request at the end of a scan.
module sbd_scan_count
    import sbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  logic                  new_breach,
    input  logic                  scan_last,
    output logic [COUNT_BITS-1:0] new_breach_count,
    output logic                  log_request
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_now;

    // The count including this beat saturates; the end of a scan clears it.
    always_comb
    begin
        count_now  = (new_breach && count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        count_next = scan_last ? '0 : count_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (commit)
        begin
            count_reg <= count_next;
        end
    end

    assign new_breach_count = count_now;
    assign log_request      = scan_last && (count_now != '0);

endmodule

>>> sv/sbd_out_reg.sv
// Result register that holds a finished beat until the receiver takes it.
module sbd_out_reg
    import sbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic    valid_reg;
    result_t result_reg;

    // A new result may enter whenever the register is empty or being emptied.
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule
